// ===== rtl/rlsd_pkg.sv =====
// Shared constants and types of the run-length image decoder.
`timescale 1ns / 1ps
`default_nettype none
package rlsd_pkg;

  localparam int ADDR_W  = 24;
  localparam int COUNT_W = 13;
  localparam int BYTE_W  = 8;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_LITERAL = 2'd1;
  localparam logic [1:0] PH_FILL    = 2'd2;

  localparam logic [BYTE_W-1:0]  LIT_FLAG    = 8'h80;
  localparam logic [BYTE_W-1:0]  LIT_MASK    = 8'h7F;
  localparam logic [BYTE_W-1:0]  FILL_BIAS   = 8'd3;
  localparam logic [BYTE_W-1:0]  MAX_LENGTH  = 8'd130;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 13'h1b00;

  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0]  base_address;
    logic [COUNT_W-1:0] dest_limit;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [BYTE_W-1:0] write_value;
    logic [BYTE_W-1:0] write_length;
    logic              image_full;
  } burst_t;

endpackage
`default_nettype wire

// ===== rtl/rlsd_ifs.sv =====
// Valid/ready channel interfaces for packed bytes in and burst commands out.
`timescale 1ns / 1ps
`default_nettype none
interface rlsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       start_req;
  modport source (output valid, output packed_byte, output start_req, input ready);
  modport sink (input valid, input packed_byte, input start_req, output ready);
endinterface

interface rlsd_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] write_address;
  logic [7:0]  write_value;
  logic [7:0]  write_length;
  logic        image_full;
  modport source (output valid, output write_address, output write_value,
                  output write_length, output image_full, input ready);
  modport sink (input valid, input write_address, input write_value,
                input write_length, input image_full, output ready);
endinterface
`default_nettype wire

// ===== rtl/rle_screen_image_decoder.sv =====
// Top level of the packbits-style run-length image decoder.
//
// Packed image bytes enter on in_ch, one item per cycle while in_ch.ready is
// high. A header byte with bit 7 set opens a literal run of (low bits + 1) bytes,
// each leaving as a burst of length 1; a header with bit 7 clear gives a fill of
// (value + 3) copies of the next byte, leaving as one burst. start_req restarts
// decoding at the byte that carries it. Bursts leave on out_ch with address,
// value, clipped length and an image_full flag; once the limit is reached bytes
// are dropped until the next start_req.
// Each burst is registered in the output stage, or in the skid register.
// Throughput: one byte per cycle while in_ch.ready is high; decode and state
// update settle in the cycle of acceptance, set by the 13-bit limit compare
// and length clip. When out_ch stalls, one further burst parks in a skid
// register and in_ch.ready falls until it drains; header bytes do not need
// the output. Reset clears the decode state and the valid flags of both
// output stages; base_address comes up 0 and dest_limit 6912. The APB port
// (psel..pready) writes at the access phase, pready always high.
`timescale 1ns / 1ps
`default_nettype none
module rle_screen_image_decoder
  import rlsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  rlsd_in_if.sink                in_ch,
  rlsd_out_if.source             out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t cfg;

  rlsd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [1:0]         phase_r, phase_nxt;
  logic [BYTE_W-1:0]  lit_r, lit_nxt;
  logic [BYTE_W-1:0]  fill_r, fill_nxt;
  logic [COUNT_W-1:0] wr_r, wr_nxt;

  logic [1:0]         phase_eff;
  logic [BYTE_W-1:0]  lit_eff, fill_eff, lit_dec, len;
  logic [COUNT_W-1:0] wr_eff, room, wr_after;
  logic               blocked, emit, accept;
  burst_t             res;

  logic   out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  burst_t out_data_r, out_data_nxt, skid_data_r, skid_data_nxt;

  assign accept = in_ch.valid && in_ch.ready;

  assign phase_eff = in_ch.start_req ? PH_HEADER : phase_r;
  assign lit_eff   = in_ch.start_req ? '0 : lit_r;
  assign fill_eff  = in_ch.start_req ? '0 : fill_r;
  assign wr_eff    = in_ch.start_req ? '0 : wr_r;
  assign blocked   = wr_eff >= cfg.dest_limit;
  assign room      = cfg.dest_limit - wr_eff;
  assign lit_dec   = (lit_eff != '0) ? lit_eff - 8'd1 : '0;

  always_comb begin
    phase_nxt = phase_eff;
    lit_nxt   = lit_eff;
    fill_nxt  = fill_eff;
    emit      = 1'b0;
    len       = 8'd1;
    if (!blocked) begin
      unique case (phase_eff)
        PH_LITERAL: begin
          lit_nxt   = lit_dec;
          phase_nxt = (lit_dec == '0) ? PH_HEADER : PH_LITERAL;
          emit      = 1'b1;
        end
        PH_FILL: begin
          len       = ({{(COUNT_W-BYTE_W){1'b0}}, fill_eff} > room) ?
                      room[BYTE_W-1:0] : fill_eff;
          phase_nxt = PH_HEADER;
          fill_nxt  = '0;
          emit      = 1'b1;
        end
        default: begin
          if ((in_ch.packed_byte & LIT_FLAG) != '0) begin
            lit_nxt   = (in_ch.packed_byte & LIT_MASK) + 8'd1;
            phase_nxt = PH_LITERAL;
          end else begin
            fill_nxt  = in_ch.packed_byte + FILL_BIAS;
            phase_nxt = PH_FILL;
          end
        end
      endcase
    end
  end

  assign wr_after = wr_eff + {{(COUNT_W-BYTE_W){1'b0}}, len};
  assign wr_nxt   = emit ? wr_after : wr_eff;

  assign res.write_address = cfg.base_address + {{(ADDR_W-COUNT_W){1'b0}}, wr_eff};
  assign res.write_value   = in_ch.packed_byte;
  assign res.write_length  = len;
  assign res.image_full    = wr_after >= cfg.dest_limit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      lit_r   <= '0;
      fill_r  <= '0;
      wr_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      lit_r   <= lit_nxt;
      fill_r  <= fill_nxt;
      wr_r    <= wr_nxt;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = accept && emit;
        out_data_nxt  = res;
      end
    end else if (accept && emit) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign in_ch.ready          = !skid_valid_r;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.write_address = out_data_r.write_address;
  assign out_ch.write_value   = out_data_r.write_value;
  assign out_ch.write_length  = out_data_r.write_length;
  assign out_ch.image_full    = out_data_r.image_full;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds an item while the output stage is empty");

  a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.write_length != '0) &&
                    (out_data_r.write_length <= MAX_LENGTH))
    else $error("burst length out of range");

  a_stall_parks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready && accept && emit) |=> skid_valid_r)
    else $error("burst lost while output stalled");

endmodule
`default_nettype wire

// ===== rtl/rlsd_regs.sv =====
// APB configuration registers: base address and destination limit.
`timescale 1ns / 1ps
`default_nettype none
module rlsd_regs
  import rlsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_BASE:  cfg_nxt.base_address = pwdata[ADDR_W-1:0];
        REG_LIMIT: cfg_nxt.dest_limit   = pwdata[COUNT_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_address <= '0;
      cfg_r.dest_limit   <= LIMIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BASE:  prdata = {{(APB_DW-ADDR_W){1'b0}}, cfg_r.base_address};
      REG_LIMIT: prdata = {{(APB_DW-COUNT_W){1'b0}}, cfg_r.dest_limit};
      default:   prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire
